FILE: hdl/stwleg_pkg.sv
// Shared constants and helpers for the leg length solver
package stwleg_pkg;

    // Field widths
    localparam int POSE_W = 20;
    localparam int LEG_W  = 22;

    // Q30 unity and reset height (1e-4 cm)
    localparam logic [30:0] ONE_Q30      = 31'(64'd1 << 30);
    localparam logic [21:0] HEIGHT_RESET = 22'd1495000;
    localparam logic [21:0] LEG_MAX      = 22'd4194303;

    // Angle to Q30 radians: mag*1874 + round-divide of mag*475409 by 14400000
    localparam int ANG_HI    = 1874;
    localparam int ANG_LO    = 475409;
    localparam int ANG_BIAS  = 7200000;
    localparam int ANG_SHIFT = 9;
    localparam int ANG_DIV   = 28125;
    localparam int ANG_RK    = 44;
    localparam logic [63:0] ANG_RM =
        ((64'd1 << ANG_RK) + 64'(ANG_DIV) - 64'd1) / 64'(ANG_DIV);

    // 1e-4 cm to Q20 cm: mag*104 + round-divide of mag*536 by 625
    localparam int POS_HI   = 104;
    localparam int POS_LO   = 536;
    localparam int POS_BIAS = 312;
    localparam int POS_DIV  = 625;
    localparam int POS_RK   = 43;
    localparam logic [63:0] POS_RM =
        ((64'd1 << POS_RK) + 64'(POS_DIV) - 64'd1) / 64'(POS_DIV);

    // Series and root depth
    localparam int SERIES_TERMS = 8;
    localparam int ROOT_STEPS   = 32;
    localparam int LEN_SCALE    = 10000;
    localparam int NUM_LEGS     = 6;

    // Constant conversion of 1e-4 cm to Q20, ties away from zero
    function automatic longint q20c(input longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = ((mag << 20) + 64'sd5000) / 64'sd10000;
        return (v < 0) ? -r : r;
    endfunction

    // Joint coordinates in Q20 cm
    localparam longint BASE_X [NUM_LEGS] = '{q20c(990152), q20c(990152), q20c(-373832),
                                             q20c(-616319), q20c(-616319), q20c(-373832)};
    localparam longint BASE_Y [NUM_LEGS] = '{q20c(-140000), q20c(140000), q20c(927496),
                                             q20c(787496), q20c(-787496), q20c(-927496)};
    localparam longint PLAT_X [NUM_LEGS] = '{q20c(491464), q20c(491464), q20c(300938),
                                             q20c(-792401), q20c(-792401), q20c(300938)};
    localparam longint PLAT_Y [NUM_LEGS] = '{q20c(-631240), q20c(631240), q20c(741240),
                                             q20c(110000), q20c(-110000), q20c(-741240)};

    // Q30 product, rounded to nearest with ties away from zero
    function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
        logic signed [67:0] p;
        logic [67:0]        m;
        logic [37:0]        r;
        p = a * b;
        m = p[67] ? 68'(-p) : 68'(p);
        r = 38'((m + (68'd1 << 29)) >> 30);
        return p[67] ? -34'(r) : 34'(r);
    endfunction

endpackage

FILE: hdl/stwleg_ifs.sv
// Pose channel
interface stwleg_pose_if;
    logic                valid;
    logic                ready;
    logic signed [19:0]  pos_x;
    logic signed [19:0]  pos_y;
    logic signed [19:0]  pos_z;
    logic signed [19:0]  roll_angle;
    logic signed [19:0]  pitch_angle;
    logic signed [19:0]  yaw_angle;

    modport source (output valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                    output ready);
endinterface

// Leg length channel
interface stwleg_legs_if;
    logic         valid;
    logic         ready;
    logic [21:0]  leg_one;
    logic [21:0]  leg_two;
    logic [21:0]  leg_three;
    logic [21:0]  leg_four;
    logic [21:0]  leg_five;
    logic [21:0]  leg_six;

    modport source (output valid, leg_one, leg_two, leg_three, leg_four, leg_five, leg_six,
                    input ready);
    modport sink   (input valid, leg_one, leg_two, leg_three, leg_four, leg_five, leg_six,
                    output ready);
endinterface

FILE: hdl/stewart_leg_length_solver.sv
// Channel   Dir  Beat contents
// pose      in   pos_x, pos_y, pos_z, roll/pitch/yaw angle (20 bit signed each)
// legs      out  leg_one .. leg_six (22 bit unsigned, 1e-4 cm)
// cfg       in   cfg_wr_en / cfg_wr_data: neutral height
//
// One pose per cycle sustained while legs.ready holds; 60 register stages. Depth
// is set by the 17-stage sine/cosine series (x squared, then two per term) and the
// 33-stage square root. Reset clears the valid bits and sets the neutral height to
// 149.5 cm. Each stage holds only while it is full and the one after it holds, so
// bubbles close up and a stalled output still lets poses enter until every stage
// is full.
module stewart_leg_length_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [21:0]        cfg_wr_data,
    stwleg_pose_if.sink        pose,
    stwleg_legs_if.source      legs
);

    localparam int ST_HS0 = 3;
    localparam int HS_N   = 2 * stwleg_pkg::SERIES_TERMS;
    localparam int ST_SIN = ST_HS0 + HS_N + 1;
    localparam int ST_R1  = ST_SIN + 1;
    localparam int ST_R2  = ST_R1 + 1;
    localparam int ST_L1  = ST_R2 + 1;
    localparam int ST_L2  = ST_L1 + 1;
    localparam int ST_L3  = ST_L2 + 1;
    localparam int ST_RT0 = ST_L3 + 1;
    localparam int ST_OUT = ST_RT0 + stwleg_pkg::ROOT_STEPS + 1;
    localparam int NST    = ST_OUT + 1;
    localparam int NL     = stwleg_pkg::NUM_LEGS;

    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][29:0]  x;
        logic [2:0][29:0]  x2;
        logic [2:0][30:0]  s;
        logic [2:0][30:0]  c;
        logic [2:0][31:0]  t;
    } horn_t;

    typedef struct packed {
        logic [NL-1:0][63:0] rem;
        logic [NL-1:0][63:0] res;
    } root_t;

    // Neutral height register
    logic [21:0] neutral_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neutral_reg <= stwleg_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            neutral_reg <= cfg_wr_data;
        end
    end

    // Stage valids and load enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || legs.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? pose.valid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign pose.ready = en[0];
    assign legs.valid = vld_reg[ST_OUT];

    // Stage 0: magnitudes and signs
    logic signed [19:0] ang_in [3];
    logic signed [19:0] pos_in [2];
    logic signed [23:0] z_sum;
    logic [19:0] ang_mag_next [3];
    logic [2:0]  ang_neg_next;
    logic [22:0] pos_mag_next [3];
    logic [2:0]  pos_neg_next;
    logic [19:0] ang_mag_reg [3];
    logic [2:0]  ang_neg_reg;
    logic [22:0] pos_mag_reg [3];
    logic [2:0]  pos_neg_reg;

    assign ang_in[0] = pose.roll_angle;
    assign ang_in[1] = pose.pitch_angle;
    assign ang_in[2] = pose.yaw_angle;
    assign pos_in[0] = pose.pos_x;
    assign pos_in[1] = pose.pos_y;
    assign z_sum = 24'(pose.pos_z) + $signed({2'b00, neutral_reg});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ang_neg_next[a] = ang_in[a][19];
            ang_mag_next[a] = ang_in[a][19] ? 20'(-ang_in[a]) : 20'(ang_in[a]);
        end
        for (int p = 0; p < 2; p++)
        begin
            pos_neg_next[p] = pos_in[p][19];
            pos_mag_next[p] = pos_in[p][19] ? {3'b000, 20'(-pos_in[p])}
                                            : {3'b000, 20'(pos_in[p])};
        end
        pos_neg_next[2] = z_sum[23];
        pos_mag_next[2] = z_sum[23] ? 23'(-z_sum) : 23'(z_sum);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ang_mag_reg <= ang_mag_next;
            ang_neg_reg <= ang_neg_next;
            pos_mag_reg <= pos_mag_next;
            pos_neg_reg <= pos_neg_next;
        end
    end

    // Stage 1: coefficient products
    logic [29:0] ang_hi_next [3];
    logic [28:0] ang_lo_next [3];
    logic [29:0] pos_hi_next [3];
    logic [32:0] pos_lo_next [3];
    logic [29:0] ang_hi_reg [3];
    logic [28:0] ang_lo_reg [3];
    logic [2:0]  ang_neg1_reg;
    logic [29:0] pos_hi_reg [3];
    logic [32:0] pos_lo_reg [3];
    logic [2:0]  pos_neg1_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ang_hi_next[a] = 30'(ang_mag_reg[a]) * 30'(stwleg_pkg::ANG_HI);
            ang_lo_next[a] = 29'((39'(ang_mag_reg[a]) * 39'(stwleg_pkg::ANG_LO)
                                  + 39'(stwleg_pkg::ANG_BIAS)) >> stwleg_pkg::ANG_SHIFT);
            pos_hi_next[a] = 30'(pos_mag_reg[a]) * 30'(stwleg_pkg::POS_HI);
            pos_lo_next[a] = 33'(pos_mag_reg[a]) * 33'(stwleg_pkg::POS_LO)
                             + 33'(stwleg_pkg::POS_BIAS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ang_hi_reg   <= ang_hi_next;
            ang_lo_reg   <= ang_lo_next;
            ang_neg1_reg <= ang_neg_reg;
            pos_hi_reg   <= pos_hi_next;
            pos_lo_reg   <= pos_lo_next;
            pos_neg1_reg <= pos_neg_reg;
        end
    end

    // Stage 2: constant divides by reciprocal, angle in Q30, position in Q20
    logic [58:0] ang_q [3];
    logic [66:0] pos_q [3];
    logic [29:0] pos_m [3];
    logic [29:0]        x_next [3];
    logic signed [31:0] t2_next [3];
    logic [29:0]        x_reg [3];
    logic [2:0]         ang_neg2_reg;
    logic signed [31:0] t2_reg [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ang_q[a]   = 59'(ang_lo_reg[a]) * 59'(stwleg_pkg::ANG_RM);
            x_next[a]  = ang_hi_reg[a] + 30'(ang_q[a] >> stwleg_pkg::ANG_RK);
            pos_q[a]   = 67'(pos_lo_reg[a]) * 67'(stwleg_pkg::POS_RM);
            pos_m[a]   = pos_hi_reg[a] + 30'(pos_q[a] >> stwleg_pkg::POS_RK);
            t2_next[a] = pos_neg1_reg[a] ? -32'(pos_m[a]) : 32'(pos_m[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            x_reg        <= x_next;
            ang_neg2_reg <= ang_neg1_reg;
            t2_reg       <= t2_next;
        end
    end

    // Series stages: x squared, then one Horner term per two stages
    horn_t hs_next [HS_N+1];
    horn_t hs_reg  [HS_N+1];

    always_comb
    begin
        hs_next[0].neg = ang_neg2_reg;
        for (int a = 0; a < 3; a++)
        begin
            hs_next[0].x[a]  = x_reg[a];
            hs_next[0].x2[a] = 30'((60'(x_reg[a]) * 60'(x_reg[a]) + (60'd1 << 29)) >> 30);
            hs_next[0].s[a]  = stwleg_pkg::ONE_Q30;
            hs_next[0].c[a]  = stwleg_pkg::ONE_Q30;
            hs_next[0].t[a]  = t2_reg[a];
        end
    end

    for (genvar h = 0; h < stwleg_pkg::SERIES_TERMS; h++)
    begin : g_term
        localparam int K  = stwleg_pkg::SERIES_TERMS - h;
        localparam int DS = 2 * K * (2 * K + 1);
        localparam int DC = (2 * K - 1) * 2 * K;
        localparam int KS = 31 + $clog2(DS);
        localparam int KC = 31 + $clog2(DC);
        localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);
        localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);

        logic [60:0] ps [3];
        logic [60:0] pc [3];
        logic [62:0] qs [3];
        logic [62:0] qc [3];

        // Scale by x squared, add half divisor
        always_comb
        begin
            hs_next[2*h+1] = hs_reg[2*h];
            for (int a = 0; a < 3; a++)
            begin
                ps[a] = 61'(hs_reg[2*h].x2[a]) * 61'(hs_reg[2*h].s[a]);
                pc[a] = 61'(hs_reg[2*h].x2[a]) * 61'(hs_reg[2*h].c[a]);
                hs_next[2*h+1].s[a] = 31'(ps[a] >> 30) + 31'(DS / 2);
                hs_next[2*h+1].c[a] = 31'(pc[a] >> 30) + 31'(DC / 2);
            end
        end

        // Divide by term constant, subtract from one
        always_comb
        begin
            hs_next[2*h+2] = hs_reg[2*h+1];
            for (int a = 0; a < 3; a++)
            begin
                qs[a] = 63'(hs_reg[2*h+1].s[a]) * 63'(MS);
                qc[a] = 63'(hs_reg[2*h+1].c[a]) * 63'(MC);
                hs_next[2*h+2].s[a] = stwleg_pkg::ONE_Q30 - 31'(qs[a] >> KS);
                hs_next[2*h+2].c[a] = stwleg_pkg::ONE_Q30 - 31'(qc[a] >> KC);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= HS_N; i++)
        begin
            if (en[ST_HS0+i])
            begin
                hs_reg[i] <= hs_next[i];
            end
        end
    end

    // Sine and cosine
    logic [60:0]        sp [3];
    logic [31:0]        sm [3];
    logic signed [31:0] sn_next [3];
    logic signed [31:0] cs_next [3];
    logic signed [31:0] sn_reg [3];
    logic signed [31:0] cs_reg [3];
    logic signed [31:0] tsin_reg [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sp[a] = 61'(hs_reg[HS_N].x[a]) * 61'(hs_reg[HS_N].s[a]) + (61'd1 << 29);
            sm[a] = 32'(sp[a] >> 30);
            sn_next[a] = hs_reg[HS_N].neg[a] ? -sm[a] : sm[a];
            cs_next[a] = 32'(hs_reg[HS_N].c[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SIN])
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
            for (int a = 0; a < 3; a++)
            begin
                tsin_reg[a] <= $signed(hs_reg[HS_N].t[a]);
            end
        end
    end

    // Rotation, first products
    logic signed [33:0] sa, ca, sb, cb, sc, cc;
    logic signed [33:0] sasb_reg, casb_reg, cbcc_reg, cbsc_reg;
    logic signed [33:0] casc_reg, cacc_reg, sasc_reg, sacc_reg;
    logic signed [33:0] sc1_reg, cc1_reg;
    logic signed [31:0] tr1_reg [3];

    assign sa = 34'(sn_reg[0]);
    assign ca = 34'(cs_reg[0]);
    assign sb = 34'(sn_reg[1]);
    assign cb = 34'(cs_reg[1]);
    assign sc = 34'(sn_reg[2]);
    assign cc = 34'(cs_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en[ST_R1])
        begin
            sasb_reg <= stwleg_pkg::mulq(sa, sb);
            casb_reg <= stwleg_pkg::mulq(ca, sb);
            cbcc_reg <= stwleg_pkg::mulq(cb, cc);
            cbsc_reg <= stwleg_pkg::mulq(cb, sc);
            casc_reg <= stwleg_pkg::mulq(ca, sc);
            cacc_reg <= stwleg_pkg::mulq(ca, cc);
            sasc_reg <= stwleg_pkg::mulq(sa, sc);
            sacc_reg <= stwleg_pkg::mulq(sa, cc);
            sc1_reg  <= sc;
            cc1_reg  <= cc;
            tr1_reg  <= tsin_reg;
        end
    end

    // Rotation, first two columns
    logic signed [33:0] rot_reg [3][2];
    logic signed [31:0] tr2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_R2])
        begin
            rot_reg[0][0] <= cbcc_reg;
            rot_reg[0][1] <= -cbsc_reg;
            rot_reg[1][0] <= stwleg_pkg::mulq(sasb_reg, cc1_reg) + casc_reg;
            rot_reg[1][1] <= cacc_reg - stwleg_pkg::mulq(sasb_reg, sc1_reg);
            rot_reg[2][0] <= sasc_reg - stwleg_pkg::mulq(casb_reg, cc1_reg);
            rot_reg[2][1] <= stwleg_pkg::mulq(casb_reg, sc1_reg) + sacc_reg;
            tr2_reg       <= tr1_reg;
        end
    end

    // Legs: rotate platform joints
    logic signed [33:0] pa_reg [NL][3];
    logic signed [33:0] pb_reg [NL][3];
    logic signed [31:0] tl1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_L1])
        begin
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pa_reg[i][j] <= stwleg_pkg::mulq(rot_reg[j][0],
                                                     34'(stwleg_pkg::PLAT_X[i]));
                    pb_reg[i][j] <= stwleg_pkg::mulq(rot_reg[j][1],
                                                     34'(stwleg_pkg::PLAT_Y[i]));
                end
            end
            tl1_reg <= tr2_reg;
        end
    end

    // Legs: add translation, subtract base joint, magnitude
    logic signed [35:0] dv [NL][3];
    logic signed [35:0] bj [NL][3];
    logic [31:0]        dm_reg [NL][3];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            bj[i][0] = 36'(stwleg_pkg::BASE_X[i]);
            bj[i][1] = 36'(stwleg_pkg::BASE_Y[i]);
            bj[i][2] = '0;
            for (int j = 0; j < 3; j++)
            begin
                dv[i][j] = 36'(pa_reg[i][j]) + 36'(pb_reg[i][j]) + 36'(tl1_reg[j]) - bj[i][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_L2])
        begin
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dm_reg[i][j] <= dv[i][j][35] ? 32'(-dv[i][j]) : 32'(dv[i][j]);
                end
            end
        end
    end

    // Legs: squares
    logic [63:0] sq_reg [NL][3];

    always_ff @(posedge clk)
    begin
        if (en[ST_L3])
        begin
            for (int i = 0; i < NL; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    sq_reg[i][j] <= 64'(dm_reg[i][j]) * 64'(dm_reg[i][j]);
                end
            end
        end
    end

    // Square root: sum into the first stage, one result bit per stage
    root_t rt_next [stwleg_pkg::ROOT_STEPS+1];
    root_t rt_reg  [stwleg_pkg::ROOT_STEPS+1];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            rt_next[0].rem[i] = (sq_reg[i][0] + sq_reg[i][1] + sq_reg[i][2]) << 2;
            rt_next[0].res[i] = '0;
        end
    end

    for (genvar g = 1; g <= stwleg_pkg::ROOT_STEPS; g++)
    begin : g_root
        localparam logic [63:0] BITV = 64'd1 << (2 * (stwleg_pkg::ROOT_STEPS - g));
        logic [63:0] trial [NL];

        always_comb
        begin
            for (int i = 0; i < NL; i++)
            begin
                trial[i] = rt_reg[g-1].res[i] + BITV;
                if (rt_reg[g-1].rem[i] >= trial[i])
                begin
                    rt_next[g].rem[i] = rt_reg[g-1].rem[i] - trial[i];
                    rt_next[g].res[i] = (rt_reg[g-1].res[i] >> 1) + BITV;
                end
                else
                begin
                    rt_next[g].rem[i] = rt_reg[g-1].rem[i];
                    rt_next[g].res[i] = rt_reg[g-1].res[i] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g <= stwleg_pkg::ROOT_STEPS; g++)
        begin
            if (en[ST_RT0+g])
            begin
                rt_reg[g] <= rt_next[g];
            end
        end
    end

    // Scale to 1e-4 cm, round, saturate
    logic [45:0] len_full [NL];
    logic [24:0] len [NL];
    logic [21:0] leg_reg [NL];

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            len_full[i] = 46'(rt_reg[stwleg_pkg::ROOT_STEPS].res[i][31:0])
                          * 46'(stwleg_pkg::LEN_SCALE) + (46'd1 << 20);
            len[i] = 25'(len_full[i] >> 21);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            for (int i = 0; i < NL; i++)
            begin
                leg_reg[i] <= (len[i] > 25'(stwleg_pkg::LEG_MAX)) ? stwleg_pkg::LEG_MAX
                                                                   : len[i][21:0];
            end
        end
    end

    assign legs.leg_one   = leg_reg[0];
    assign legs.leg_two   = leg_reg[1];
    assign legs.leg_three = leg_reg[2];
    assign legs.leg_four  = leg_reg[3];
    assign legs.leg_five  = leg_reg[4];
    assign legs.leg_six   = leg_reg[5];

    // Checks
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pose.valid && pose.ready |=> vld_reg[0])
        else $error("accepted pose did not enter first stage");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !pose.ready |-> (&vld_reg) && !legs.ready)
        else $error("input stalled while pipeline has a bubble");

    a_series: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_HS0+HS_N] |-> hs_reg[HS_N].s[0] <= stwleg_pkg::ONE_Q30
                                 && hs_reg[HS_N].c[0] <= stwleg_pkg::ONE_Q30)
        else $error("series term above unity");

endmodule
